/* design/assert_macros.svh */
// Assertion macros shared by the file signature classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/fsc_pkg.sv */
// Package for the file signature classifier: constants, types and match helpers.
package fsc_pkg;

	localparam int HEAD_BYTES = 1024;
	localparam int PosW       = $clog2(HEAD_BYTES + 1);
	localparam int SigBytes   = 12;
	localparam int EmfOffset  = 40;

	typedef logic [PosW-1:0]              pos_t;
	typedef logic [SigBytes-1:0][7:0]     head_t;
	typedef logic [5:0]                   code_t;

	// Type codes
	localparam code_t T_UNKNOWN = 6'd0;
	localparam code_t T_ZIP     = 6'd1;
	localparam code_t T_CFB     = 6'd2;
	localparam code_t T_PDF     = 6'd3;
	localparam code_t T_PNG     = 6'd4;
	localparam code_t T_JPEG    = 6'd5;
	localparam code_t T_BMP     = 6'd6;
	localparam code_t T_GIF     = 6'd7;
	localparam code_t T_SVM     = 6'd8;
	localparam code_t T_RTF     = 6'd9;
	localparam code_t T_WPD     = 6'd10;
	localparam code_t T_OTF     = 6'd11;
	localparam code_t T_TTF     = 6'd12;
	localparam code_t T_WEBP    = 6'd13;
	localparam code_t T_WAVE    = 6'd14;
	localparam code_t T_AVI     = 6'd15;
	localparam code_t T_QT      = 6'd16;
	localparam code_t T_3GP     = 6'd17;
	localparam code_t T_AVIF    = 6'd18;
	localparam code_t T_HEIF    = 6'd19;
	localparam code_t T_M4A     = 6'd20;
	localparam code_t T_MP4     = 6'd21;
	localparam code_t T_TIFF    = 6'd22;
	localparam code_t T_MKV     = 6'd23;
	localparam code_t T_OGG     = 6'd24;
	localparam code_t T_FLAC    = 6'd25;
	localparam code_t T_MP3     = 6'd26;
	localparam code_t T_ICO     = 6'd27;
	localparam code_t T_JP2     = 6'd28;
	localparam code_t T_JXL     = 6'd29;
	localparam code_t T_PSD     = 6'd30;
	localparam code_t T_WMF     = 6'd31;
	localparam code_t T_EMF     = 6'd32;
	localparam code_t T_SVG     = 6'd33;

	// Characters
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] BOM_0    = 8'hEF;
	localparam logic [7:0] BOM_1    = 8'hBB;
	localparam logic [7:0] BOM_2    = 8'hBF;

	// Prefix match: pat holds byte 0 in its top eight bits; wild marks skipped bytes.
	function automatic logic sig_hit(input head_t h, input pos_t pos, input int n,
			input logic [8*SigBytes-1:0] pat, input logic [SigBytes-1:0] wild);
		logic ok;
		ok = (pos >= PosW'(n));
		for (int i = 0; i < SigBytes; i++) begin
			if (i < n && !wild[i] && h[i] != pat[8*SigBytes-1-8*i -: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

/* design/fsc_svg_fsm.sv */
// SVG root element detector: walks the prologue one byte at a time.
module fsc_svg_fsm (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       clear,
	input  logic [7:0] byte_in,
	output logic       svg_hit
);
	import fsc_pkg::*;

	localparam logic [3:0] SV_BOM0   = 4'd0;
	localparam logic [3:0] SV_BOM1   = 4'd1;
	localparam logic [3:0] SV_BOM2   = 4'd2;
	localparam logic [3:0] SV_PROLOG = 4'd3;
	localparam logic [3:0] SV_LT     = 4'd4;
	localparam logic [3:0] SV_BANG   = 4'd5;
	localparam logic [3:0] SV_BANGD  = 4'd6;
	localparam logic [3:0] SV_CMT    = 4'd7;
	localparam logic [3:0] SV_PI     = 4'd8;
	localparam logic [3:0] SV_ITEM   = 4'd9;
	localparam logic [3:0] SV_NAME   = 4'd10;
	localparam logic [3:0] SV_YES    = 4'd11;
	localparam logic [3:0] SV_NO     = 4'd12;

	logic [3:0]  st_q, st_d;
	logic [15:0] pair_q, pair_d;
	logic [1:0]  cnt_q, cnt_d, nc;
	logic        brk_q, brk_d, col_q, col_d, nb, ncol;
	logic        is_ws, is_term;
	logic [7:0]  want;

	always_comb begin
		is_ws   = byte_in == CH_SP || byte_in == CH_TAB || byte_in == CH_CR || byte_in == CH_LF;
		is_term = is_ws || byte_in == CH_SLASH || byte_in == CH_GT;
		// root name starts fresh right after the opening bracket
		nc   = (st_q == SV_LT) ? 2'd0 : cnt_q;
		nb   = (st_q == SV_LT) ? 1'b0 : brk_q;
		ncol = (st_q == SV_LT) ? 1'b0 : col_q;
		case (nc)
			2'd0:    want = CH_S;
			2'd1:    want = CH_V;
			default: want = CH_G;
		endcase
		st_d   = st_q;
		cnt_d  = cnt_q;
		brk_d  = brk_q;
		col_d  = col_q;
		pair_d = pair_q;
		if (step) begin
			pair_d = {pair_q[7:0], byte_in};
			case (st_q)
				SV_BOM0: begin
					if (byte_in == BOM_0) st_d = SV_BOM1;
					else if (is_ws) st_d = SV_PROLOG;
					else if (byte_in == CH_LT) st_d = SV_LT;
					else st_d = SV_NO;
				end
				SV_BOM1: st_d = (byte_in == BOM_1) ? SV_BOM2 : SV_NO;
				SV_BOM2: st_d = (byte_in == BOM_2) ? SV_PROLOG : SV_NO;
				SV_PROLOG: begin
					if (byte_in == CH_LT) st_d = SV_LT;
					else if (!is_ws) st_d = SV_NO;
				end
				SV_BANG, SV_BANGD: begin
					if (byte_in == CH_DASH) st_d = (st_q == SV_BANG) ? SV_BANGD : SV_CMT;
					else if (byte_in == CH_GT) st_d = SV_PROLOG;
					else st_d = SV_ITEM;
				end
				SV_CMT: begin
					if (byte_in == CH_GT && pair_q == {CH_DASH, CH_DASH}) st_d = SV_PROLOG;
				end
				SV_PI: begin
					if (byte_in == CH_GT && pair_q[7:0] == CH_QM) st_d = SV_PROLOG;
				end
				SV_ITEM: begin
					if (byte_in == CH_GT) st_d = SV_PROLOG;
				end
				SV_LT, SV_NAME: begin
					if (st_q == SV_LT && byte_in == CH_QM) st_d = SV_PI;
					else if (st_q == SV_LT && byte_in == CH_BANG) st_d = SV_BANG;
					else if (is_term) begin
						st_d = (!nb && nc == 2'd3) ? SV_YES : SV_NO;
					end else begin
						st_d  = SV_NAME;
						cnt_d = nc;
						brk_d = nb;
						col_d = ncol;
						// drop one namespace prefix up to the first colon
						if (byte_in == CH_COLON && !ncol) begin
							col_d = 1'b1;
							cnt_d = 2'd0;
							brk_d = 1'b0;
						end else if (!nb && nc != 2'd3 && byte_in == want) begin
							cnt_d = nc + 2'd1;
						end else begin
							brk_d = 1'b1;
						end
					end
				end
				SV_YES:  st_d = SV_YES;
				default: st_d = SV_NO;
			endcase
		end
	end

	assign svg_hit = (st_d == SV_YES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SV_BOM0;
			pair_q <= '0;
			cnt_q  <= '0;
			brk_q  <= 1'b0;
			col_q  <= 1'b0;
		end else if (clear) begin
			st_q   <= SV_BOM0;
			pair_q <= '0;
			cnt_q  <= '0;
			brk_q  <= 1'b0;
			col_q  <= 1'b0;
		end else begin
			st_q   <= st_d;
			pair_q <= pair_d;
			cnt_q  <= cnt_d;
			brk_q  <= brk_d;
			col_q  <= col_d;
		end
	end

endmodule

/* design/fsc_classify.sv */
// Priority classifier over the captured head bytes, form tags and SVG flag.
module fsc_classify (
	input  fsc_pkg::head_t h,
	input  fsc_pkg::pos_t  pos,
	input  logic [31:0]    emf_tag,
	input  logic           svg_hit,
	output fsc_pkg::code_t code
);
	import fsc_pkg::*;

	localparam logic [11:0] NW = 12'h000;

	logic [31:0] tag;
	logic        tag_ok, emf_ok;

	always_comb begin
		tag    = {h[8], h[9], h[10], h[11]};
		tag_ok = pos >= PosW'(12);
		emf_ok = pos >= PosW'(EmfOffset + 4);
		code   = T_UNKNOWN;
		if (sig_hit(h, pos, 4, 96'h504B0304_0000000000000000, NW)) code = T_ZIP;
		else if (sig_hit(h, pos, 8, 96'hD0CF11E0A1B11AE1_00000000, NW)) code = T_CFB;
		else if (sig_hit(h, pos, 5, 96'h255044462D_00000000000000, NW)) code = T_PDF;
		else if (sig_hit(h, pos, 8, 96'h89504E470D0A1A0A_00000000, NW)) code = T_PNG;
		else if (sig_hit(h, pos, 4, 96'hFFD8FFDB_0000000000000000, NW) ||
				sig_hit(h, pos, 12, 96'hFFD8FFE000104A4649460001, NW) ||
				sig_hit(h, pos, 4, 96'hFFD8FFEE_0000000000000000, NW) ||
				sig_hit(h, pos, 12, 96'hFFD8FFE10000457869660000, 12'h030))
			code = T_JPEG;
		else if (sig_hit(h, pos, 2, 96'h424D_00000000000000000000, NW)) code = T_BMP;
		else if (sig_hit(h, pos, 6, 96'h474946383761_000000000000, NW) ||
				sig_hit(h, pos, 6, 96'h474946383961_000000000000, NW))
			code = T_GIF;
		else if (sig_hit(h, pos, 6, 96'h56434C4D5446_000000000000, NW)) code = T_SVM;
		else if (sig_hit(h, pos, 6, 96'h7B5C72746631_000000000000, NW)) code = T_RTF;
		else if (sig_hit(h, pos, 4, 96'hFF575043_0000000000000000, NW)) code = T_WPD;
		else if (sig_hit(h, pos, 4, 96'h4F54544F_0000000000000000, NW)) code = T_OTF;
		else if (sig_hit(h, pos, 4, 96'h00010000_0000000000000000, NW) ||
				sig_hit(h, pos, 4, 96'h74727565_0000000000000000, NW) ||
				sig_hit(h, pos, 4, 96'h74746366_0000000000000000, NW))
			code = T_TTF;
		else if (sig_hit(h, pos, 4, 96'h52494646_0000000000000000, NW) && tag_ok &&
				(tag == 32'h57454250 || tag == 32'h57415645 || tag == 32'h41564920)) begin
			// RIFF with a known form; an unknown form falls through
			if (tag == 32'h57454250) code = T_WEBP;
			else if (tag == 32'h57415645) code = T_WAVE;
			else code = T_AVI;
		end
		else if (sig_hit(h, pos, 8, 96'h0000000066747970_00000000, 12'h00F)) begin
			if (tag_ok && tag == 32'h71742020) code = T_QT;
			else if (tag_ok && tag[31:16] == 16'h3367) code = T_3GP;
			else if (tag_ok && (tag == 32'h61766966 || tag == 32'h61766973)) code = T_AVIF;
			else if (tag_ok && (tag[31:8] == 24'h686569 || tag[31:8] == 24'h686576 ||
					tag == 32'h6D696631 || tag == 32'h6D736631))
				code = T_HEIF;
			else if (tag_ok && (tag[31:8] == 24'h4D3441 || tag[31:8] == 24'h4D3442))
				code = T_M4A;
			else code = T_MP4;
		end
		else if (sig_hit(h, pos, 4, 96'h49492A00_0000000000000000, NW) ||
				sig_hit(h, pos, 4, 96'h4D4D002A_0000000000000000, NW))
			code = T_TIFF;
		else if (sig_hit(h, pos, 4, 96'h1A45DFA3_0000000000000000, NW)) code = T_MKV;
		else if (sig_hit(h, pos, 4, 96'h4F676753_0000000000000000, NW)) code = T_OGG;
		else if (sig_hit(h, pos, 4, 96'h664C6143_0000000000000000, NW)) code = T_FLAC;
		else if (sig_hit(h, pos, 3, 96'h494433_000000000000000000, NW) ||
				sig_hit(h, pos, 2, 96'hFFFB_00000000000000000000, NW) ||
				sig_hit(h, pos, 2, 96'hFFF3_00000000000000000000, NW) ||
				sig_hit(h, pos, 2, 96'hFFF2_00000000000000000000, NW) ||
				sig_hit(h, pos, 2, 96'hFFFA_00000000000000000000, NW))
			code = T_MP3;
		else if (sig_hit(h, pos, 4, 96'h00000100_0000000000000000, NW) ||
				sig_hit(h, pos, 4, 96'h00000200_0000000000000000, NW))
			code = T_ICO;
		else if (sig_hit(h, pos, 12, 96'h0000000C6A5020200D0A870A, NW) ||
				sig_hit(h, pos, 4, 96'hFF4FFF51_0000000000000000, NW))
			code = T_JP2;
		else if (sig_hit(h, pos, 12, 96'h0000000C4A584C200D0A870A, NW)) code = T_JXL;
		else if (sig_hit(h, pos, 4, 96'h38425053_0000000000000000, NW)) code = T_PSD;
		else if (sig_hit(h, pos, 4, 96'hD7CDC69A_0000000000000000, NW) ||
				sig_hit(h, pos, 6, 96'h010009000003_000000000000, NW) ||
				sig_hit(h, pos, 6, 96'h020009000003_000000000000, NW))
			code = T_WMF;
		else if (sig_hit(h, pos, 4, 96'h01000000_0000000000000000, NW) && emf_ok &&
				emf_tag == 32'h20454D46)
			code = T_EMF;
		else if (sig_hit(h, pos, 2, 96'hFF0A_00000000000000000000, NW)) code = T_JXL;
		else if (svg_hit) code = T_SVG;
	end

endmodule

/* design/file_signature_classifier.sv */
// Top level of the file signature classifier.
// Feed the head of a file one byte per transfer (has_byte marks a real byte; only the
// empty file sends has_byte 0). The first HEAD_BYTES bytes count, later ones are
// dropped. The transfer marked last yields exactly one type_code transfer in the next
// cycle, and the block is then clear for the next file. One input transfer is taken
// each unstalled cycle: the byte goes into the capture registers and the SVG walker,
// and classification of a last transfer is a single pass of compare logic into the
// output register. in_stall rises only while a finished code waits under out_stall.
module file_signature_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        head_byte,
	input  logic              has_byte,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        type_code
);
	import fsc_pkg::*;
	`include "assert_macros.svh"

	head_t       head_q, head_n;
	logic [31:0] emf_q, emf_n;
	pos_t        pos_q, pos_n;
	logic        in_acc, keep, svg_hit;
	code_t       code_n, code_q;
	logic        out_valid_q;

	// Hold new input only while a finished code is stuck at the output.
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign keep     = in_acc && has_byte && (pos_q < PosW'(HEAD_BYTES));

	// Next view of the head: the classifier sees the byte of this transfer too.
	always_comb begin
		head_n = head_q;
		emf_n  = emf_q;
		pos_n  = pos_q + PosW'(keep);
		for (int i = 0; i < SigBytes; i++) begin
			if (keep && pos_q == PosW'(i))
				head_n[i] = head_byte;
		end
		// Capture the metafile tag; the offset is a multiple of four.
		if (keep && pos_q >= PosW'(EmfOffset) && pos_q < PosW'(EmfOffset + 4))
			emf_n[31 - 8*pos_q[1:0] -: 8] = head_byte;
	end

	fsc_svg_fsm u_svg (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (keep),
		.clear   (in_acc && last),
		.byte_in (head_byte),
		.svg_hit (svg_hit)
	);

	fsc_classify u_cls (
		.h       (head_n),
		.pos     (pos_n),
		.emf_tag (emf_n),
		.svg_hit (svg_hit),
		.code    (code_n)
	);

	// Capture registers; advance on every kept byte, drop back to empty after last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc && last) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_n;
		emf_q  <= emf_n;
		if (in_acc && last)
			code_q <= code_n;
	end

	// Output register: load on last, release once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign type_code = code_q;

	`FSC_ASSERT_NXT(a_last_gives_code, in_acc && last, out_valid, "last transfer gave no code")
	`FSC_ASSERT_NXT(a_last_clears_pos, in_acc && last, pos_q == '0, "head not cleared after last")
	`FSC_ASSERT_NXT(a_taken_drains, !in_acc && out_valid && !out_stall, !out_valid,
		"code repeated after transfer")
	`FSC_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= PosW'(HEAD_BYTES), "head count overflow")

endmodule
